/* hdl/lkx_pkg.sv */
// shared types and constants for the lcg keystream xor cipher
`timescale 1ns / 1ps

package lkx_pkg;

   // key and register width
   localparam int KEY_W    = 32;
   localparam int BYTE_W   = 8;
   localparam int CSR_IDX_W = 8;
   localparam int STEP_W   = $clog2(KEY_W);

   // register defaults taken when a register holds zero
   localparam logic [KEY_W-1:0] DEF_SEED       = 32'd1;
   localparam logic [KEY_W-1:0] DEF_MODULUS    = 32'd1 << 19;
   localparam logic [KEY_W-1:0] DEF_MULTIPLIER = 32'd2 << 20;
   localparam logic [KEY_W-1:0] DEF_INCREMENT  = 32'd3 << 21;

   // keystream byte position inside the key
   localparam int KEY_SHIFT = 20;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SEED       = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS    = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MULTIPLIER = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INCREMENT  = 8'd3;

   // request payload
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              first_of_message;
      logic              last_of_message;
   } req_type;

   // response payload
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              out_last;
   } rsp_type;

   // remainder unit status
   typedef struct packed {
      logic busy;
      logic done;
   } rem_status_type;

endpackage

/* hdl/lcg_keystream_xor_cipher.sv */
// top level of the lcg keystream xor cipher: registers, sequencer, output stage
`timescale 1ns / 1ps
//
// Byte stream cipher: each request carries one byte plus first/last marks;
// each request yields exactly one response with the byte xored against
// bits 27..20 of the advanced running key. Same operation both ways.
// Request channel req_valid/req_ready/req_payload, response channel
// rsp_valid/rsp_ready/rsp_payload, register writes on csr_valid/csr_ready
// with csr_index (0 seed, 1 modulus, 2 multiplier, 3 increment) and
// csr_data; other indexes are ignored. csr_ready is always high; write
// registers only while no request is in flight.
// A request runs the 32 steps of the bit-serial key remainder, then one
// multiply and one add/output step; a new request is taken only once the
// block is back in its idle state, so requests are not overlapped.
// The response sits in an output register, so the next request is taken
// while it waits; if rsp_ready stays low the block holds in its final
// step until the output register frees up.
// Reset clears the four csr registers and the running key to zero, so defaults
// apply; no first mark after reset advances from a key of zero.
//
module lcg_keystream_xor_cipher (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  lkx_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output lkx_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lkx_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lkx_pkg::KEY_W-1:0]         csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_ADD
   } state_type;

   state_type                  state_ff, state_in;
   logic [lkx_pkg::KEY_W-1:0]  seed_ff, modulus_ff, multiplier_ff, increment_ff;
   logic [lkx_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [lkx_pkg::KEY_W-1:0]  prod_ff, prod_in;
   logic [lkx_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic                       last_ff, last_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   lkx_pkg::rsp_type           rsp_payload_ff, rsp_payload_in;

   logic [lkx_pkg::KEY_W-1:0]  seed_eff, mod_eff, mult_eff, inc_eff;
   logic [lkx_pkg::KEY_W-1:0]  key_src;
   logic [lkx_pkg::KEY_W-1:0]  rem_value;
   logic [lkx_pkg::KEY_W-1:0]  key_next;
   lkx_pkg::rem_status_type    rem_status;
   logic                       req_accept;
   logic                       out_free;

   // register file writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff       <= '0;
         modulus_ff    <= '0;
         multiplier_ff <= '0;
         increment_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            lkx_pkg::CSR_SEED:       seed_ff       <= csr_data;
            lkx_pkg::CSR_MODULUS:    modulus_ff    <= csr_data;
            lkx_pkg::CSR_MULTIPLIER: multiplier_ff <= csr_data;
            lkx_pkg::CSR_INCREMENT:  increment_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // zero selects the default value
   assign seed_eff = (seed_ff == '0)       ? lkx_pkg::DEF_SEED       : seed_ff;
   assign mod_eff  = (modulus_ff == '0)    ? lkx_pkg::DEF_MODULUS    : modulus_ff;
   assign mult_eff = (multiplier_ff == '0) ? lkx_pkg::DEF_MULTIPLIER : multiplier_ff;
   assign inc_eff  = (increment_ff == '0)  ? lkx_pkg::DEF_INCREMENT  : increment_ff;

   // request handshake and key source
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign key_src    = req_payload.first_of_message ? seed_eff : key_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign key_next   = prod_ff + inc_eff;

   // key mod modulus
   lkx_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .dividend  (key_src),
      .divisor   (mod_eff),
      .remainder (rem_value),
      .status    (rem_status)
   );

   // sequencer
   always_comb begin
      state_in       = state_ff;
      key_in         = key_ff;
      prod_in        = prod_ff;
      byte_in        = byte_ff;
      last_in        = last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               byte_in  = req_payload.data_byte;
               last_in  = req_payload.last_of_message;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_status.done) begin
               prod_in  = mult_eff * rem_value;
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (out_free) begin
               key_in                  = key_next;
               rsp_payload_in.out_byte = byte_ff ^ key_next[lkx_pkg::KEY_SHIFT +:
                                                            lkx_pkg::BYTE_W];
               rsp_payload_in.out_last = last_ff;
               rsp_valid_in            = 1'b1;
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_ff       <= key_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff        <= prod_in;
      byte_ff        <= byte_in;
      last_ff        <= last_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   // an accepted request starts the remainder unit
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_DIV && rem_status.busy))
      else $error("request accepted without starting remainder");

   // remainder completion moves on to the add step
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && rem_status.done) |=> (state_ff == ST_ADD))
      else $error("remainder done ignored");

   // the remainder unit only runs while a request is in flight
   assert property (@(posedge clock) disable iff (reset)
      rem_status.busy |-> (state_ff == ST_DIV))
      else $error("remainder busy outside divide state");
`endif

endmodule

/* hdl/lkx_rem_unit.sv */
// iterative restoring remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps

module lkx_rem_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lkx_pkg::KEY_W-1:0]    dividend,
   input  logic [lkx_pkg::KEY_W-1:0]    divisor,
   output logic [lkx_pkg::KEY_W-1:0]    remainder,
   output lkx_pkg::rem_status_type      status
);

   logic [lkx_pkg::KEY_W-1:0]  rem_ff, rem_in;
   logic [lkx_pkg::KEY_W-1:0]  dvd_ff, dvd_in;
   logic [lkx_pkg::KEY_W-1:0]  div_ff, div_in;
   logic [lkx_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [lkx_pkg::KEY_W:0]    trial;
   logic [lkx_pkg::KEY_W:0]    diff;

   // shift in the next dividend bit and try a subtract
   assign trial = {rem_ff, dvd_ff[lkx_pkg::KEY_W-1]};
   assign diff  = trial - {1'b0, div_ff};

   // step sequencing
   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         dvd_in  = dividend;
         div_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[lkx_pkg::KEY_W-1:0];
         end else begin
            rem_in = trial[lkx_pkg::KEY_W-1:0];
         end
         dvd_in  = {dvd_ff[lkx_pkg::KEY_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == lkx_pkg::STEP_W'(lkx_pkg::KEY_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      div_ff  <= div_in;
      step_ff <= step_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

`ifndef SYNTHESIS
   // done is a single pulse after the busy phase
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("remainder done while busy");

   // last step always raises done
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && step_ff == lkx_pkg::STEP_W'(lkx_pkg::KEY_W - 1)) |=> done_ff)
      else $error("remainder missed done after last step");

   // finished remainder is below the divisor
   assert property (@(posedge clock) disable iff (reset)
      (done_ff && div_ff != '0) |-> (rem_ff < div_ff))
      else $error("remainder not below divisor");
`endif

endmodule

/* verif/tb.sv */
// self-checking testbench for the lcg keystream xor cipher
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int PHASE_ITEMS   = 200;
   localparam int RANDOM_PHASES = 8;
   localparam int SETTLE_CYCLES = 80;
   localparam int LONG_HOLD     = 400;

   // indexes outside the register map, which the block must ignore
   localparam logic [lkx_pkg::CSR_IDX_W-1:0] CSR_UNUSED_LO = 8'd4;
   localparam logic [lkx_pkg::CSR_IDX_W-1:0] CSR_UNUSED_HI = 8'hff;

   // predicted cipher state and the bytes still owed by the block
   class cipher_tracker;
      logic [lkx_pkg::KEY_W-1:0] seed_reg;
      logic [lkx_pkg::KEY_W-1:0] modulus_reg;
      logic [lkx_pkg::KEY_W-1:0] multiplier_reg;
      logic [lkx_pkg::KEY_W-1:0] increment_reg;
      logic [lkx_pkg::KEY_W-1:0] key;
      lkx_pkg::rsp_type          owed_q[$];
      int                        fail_count;

      function new();
         seed_reg       = '0;
         modulus_reg    = '0;
         multiplier_reg = '0;
         increment_reg  = '0;
         key            = '0;
         fail_count     = 0;
      endfunction

      function void set_register(logic [lkx_pkg::CSR_IDX_W-1:0] idx,
                                 logic [lkx_pkg::KEY_W-1:0] value);
         case (idx)
            lkx_pkg::CSR_SEED:       seed_reg = value;
            lkx_pkg::CSR_MODULUS:    modulus_reg = value;
            lkx_pkg::CSR_MULTIPLIER: multiplier_reg = value;
            lkx_pkg::CSR_INCREMENT:  increment_reg = value;
            default: ;
         endcase
      endfunction

      // advance the key for one request and queue the byte it yields
      function void take_request(lkx_pkg::req_type r);
         logic [lkx_pkg::KEY_W-1:0] m;
         logic [lkx_pkg::KEY_W-1:0] a;
         logic [lkx_pkg::KEY_W-1:0] c;
         lkx_pkg::rsp_type          e;
         m = (modulus_reg == '0) ? lkx_pkg::DEF_MODULUS : modulus_reg;
         a = (multiplier_reg == '0) ? lkx_pkg::DEF_MULTIPLIER : multiplier_reg;
         c = (increment_reg == '0) ? lkx_pkg::DEF_INCREMENT : increment_reg;
         if (r.first_of_message)
            key = (seed_reg == '0) ? lkx_pkg::DEF_SEED : seed_reg;
         key = a * (key % m) + c;
         e.out_byte = r.data_byte ^ key[lkx_pkg::KEY_SHIFT +: lkx_pkg::BYTE_W];
         e.out_last = r.last_of_message;
         owed_q.push_back(e);
      endfunction

      // compare one response against the oldest owed byte
      function void match_response(lkx_pkg::rsp_type r);
         lkx_pkg::rsp_type e;
         if (owed_q.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected response, expected none, actual byte %02h last %0b",
                     $time, r.out_byte, r.out_last);
            return;
         end
         e = owed_q.pop_front();
         if (r.out_byte !== e.out_byte) begin
            fail_count++;
            $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                     $time, e.out_byte, r.out_byte);
         end
         if (r.out_last !== e.out_last) begin
            fail_count++;
            $display("%0t: out_last mismatch, expected %0b, actual %0b",
                     $time, e.out_last, r.out_last);
         end
      endfunction

      // anything still owed at the end is a failure
      function void close_out();
         if (owed_q.size() != 0) begin
            $display("%0t: %0d responses never arrived", $time, owed_q.size());
            fail_count += owed_q.size();
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   lkx_pkg::req_type              req_payload = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   lkx_pkg::rsp_type              rsp_payload;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [lkx_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [lkx_pkg::KEY_W-1:0]     csr_data = '0;

   cipher_tracker book = new();
   int  cycle_count = 0;
   bit  idle_on = 1'b0;
   bit  hold_rsp_off = 1'b0;

   lcg_keystream_xor_cipher dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #10 clock = ~clock;

   // watch all three channels at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            book.set_register(csr_index, csr_data);
         if (req_valid && req_ready)
            book.take_request(req_payload);
         if (rsp_valid && rsp_ready)
            book.match_response(rsp_payload);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // response side: random ready with short and long stalls, one very long hold
   initial begin : rsp_side
      int span;
      bit level;
      @(posedge clock);
      forever begin
         if (hold_rsp_off) begin
            hold_rsp_off = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            if (!idle_on) begin
               level = 1'b1;
               span  = $urandom_range(1, 40);
            end else begin
               level = ($urandom_range(0, 3) != 0);
               span  = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60)
                                                    : $urandom_range(1, 4);
            end
            rsp_ready <= level;
            repeat (span) @(posedge clock);
         end
      end
   end

   // idle cycles before the next request: mostly none, rarely long
   function automatic int pick_gap();
      int r;
      if (!idle_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // register values with the corner cases weighted up
   function automatic logic [lkx_pkg::KEY_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 32'd1;
         2: return '1;
         3: return 32'h8000_0000;
         4: return $urandom_range(2, 255);
         default: return $urandom();
      endcase
   endfunction

   // offer one request; valid stays high afterwards unless a gap follows
   task automatic send_byte(input logic [lkx_pkg::BYTE_W-1:0] b, input bit first,
                            input bit last);
      lkx_pkg::req_type p;
      int               gap;
      p.data_byte        = b;
      p.first_of_message = first;
      p.last_of_message  = last;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop offering and wait for every owed response
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (book.owed_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [lkx_pkg::CSR_IDX_W-1:0] idx,
                            input logic [lkx_pkg::KEY_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // mostly well-formed messages with random bytes, some with random marks
   task automatic run_messages(input int budget);
      int sent;
      int len;
      int k;
      bit tidy;
      sent = 0;
      while (sent < budget) begin
         tidy = ($urandom_range(0, 99) < 85);
         if (tidy)
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 12);
         else
            len = $urandom_range(1, 6);
         for (k = 0; k < len && sent < budget; k++) begin
            if (tidy)
               send_byte(lkx_pkg::BYTE_W'($urandom()), k == 0, k == len - 1);
            else
               send_byte(lkx_pkg::BYTE_W'($urandom()), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      int ph;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // no first mark after reset: key walks on from zero with all defaults
      send_byte(8'h00, 0, 0);
      send_byte(8'hff, 0, 0);
      send_byte(8'ha5, 0, 1);
      // no first mark after a last mark: key carries on
      send_byte(8'h5a, 0, 0);
      send_byte(8'h80, 0, 1);
      // single-byte messages, then a short one from the default seed
      send_byte(8'h01, 1, 1);
      send_byte(8'hfe, 1, 1);
      send_byte(8'h00, 1, 0);
      send_byte(8'hff, 0, 0);
      send_byte(8'h7f, 0, 1);
      drain();

      // all registers at full scale: multiply and add wrap
      csr_write(lkx_pkg::CSR_SEED, '1);
      csr_write(lkx_pkg::CSR_MODULUS, '1);
      csr_write(lkx_pkg::CSR_MULTIPLIER, '1);
      csr_write(lkx_pkg::CSR_INCREMENT, '1);
      send_byte(8'hff, 1, 0);
      send_byte(8'h00, 0, 0);
      send_byte(8'h55, 0, 1);
      send_byte(8'haa, 1, 1);
      drain();

      // registers changed inside a message: new seed waits for the next first mark,
      // unit modulus pins the key to the increment
      csr_write(lkx_pkg::CSR_SEED, 32'h8000_0001);
      csr_write(lkx_pkg::CSR_MODULUS, 32'd1);
      csr_write(lkx_pkg::CSR_MULTIPLIER, 32'h0001_0001);
      csr_write(lkx_pkg::CSR_INCREMENT, 32'h0ff0_0000);
      send_byte(8'h3c, 0, 0);
      send_byte(8'hc3, 0, 1);
      send_byte(8'h3c, 1, 1);
      drain();

      // unused indexes change nothing; zero brings each default back
      csr_write(CSR_UNUSED_LO, 32'hdead_beef);
      csr_write(CSR_UNUSED_HI, 32'h1234_5678);
      csr_write(lkx_pkg::CSR_MODULUS, '0);
      csr_write(lkx_pkg::CSR_INCREMENT, '0);
      send_byte(8'h96, 0, 1);
      send_byte(8'h69, 1, 0);
      drain();
      csr_write(lkx_pkg::CSR_SEED, '0);
      csr_write(lkx_pkg::CSR_MULTIPLIER, '0);
      send_byte(8'h0f, 1, 1);
      drain();

      // random phases, each with fresh register settings
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         idle_on = (ph % 3 != 1);
         if ($urandom_range(0, 2) != 0)
            csr_write(lkx_pkg::CSR_SEED, pick_word());
         if ($urandom_range(0, 2) != 0)
            csr_write(lkx_pkg::CSR_MODULUS, pick_word());
         if ($urandom_range(0, 2) != 0)
            csr_write(lkx_pkg::CSR_MULTIPLIER, pick_word());
         if ($urandom_range(0, 2) != 0)
            csr_write(lkx_pkg::CSR_INCREMENT, pick_word());
         if ($urandom_range(0, 3) == 0)
            csr_write(lkx_pkg::CSR_IDX_W'($urandom_range(CSR_UNUSED_LO, CSR_UNUSED_HI)),
                      $urandom());
         // receiver goes quiet for a long while so the block backs up
         if (ph == 2)
            hold_rsp_off = 1'b1;
         run_messages(PHASE_ITEMS);
         drain();
      end

      idle_on = 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      book.close_out();
      if (book.fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* sim.f */
hdl/lkx_pkg.sv
hdl/lkx_rem_unit.sv
hdl/lcg_keystream_xor_cipher.sv
verif/tb.sv
